// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rv32x_pkg.sv -----
// types and constants for the rv32i subset execute block
// no dependencies
package rv32x_pkg;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;

  localparam logic [31:0] SP_RESET   = 32'd256;
  localparam logic [4:0]  SP_INDEX   = 5'd2;
  localparam logic [31:0] BASE_RESET = 32'd65536;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNSUP  = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic        rd_write;
    logic        mem_write;
    logic [1:0]  status;
  } result_t;

endpackage

// ----- rtl/rv32x_regfile.sv -----
// 32 x 32 register file: one write port, two registered read ports
// uses rv32x_pkg; stack pointer reset emulated by a valid bit per entry
module rv32x_regfile
  import rv32x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [4:0]  ra_a,
  input  logic [4:0]  ra_b,
  output logic [31:0] rdata_a,
  output logic [31:0] rdata_b,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd
);

  logic [31:0] mem_a [32];
  logic [31:0] mem_b [32];
  logic [31:0] vld_r;
  logic [31:0] qa_r, qb_r;
  logic        va_r, vb_r;
  logic [4:0]  ia_r, ib_r;
  logic        hit_a, hit_b;

  // a read of the entry being written returns the new data
  assign hit_a = we && (wa == ra_a);
  assign hit_b = we && (wa == ra_b);

  // two copies so each read port has its own array
  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[wa] <= wd;
      mem_b[wa] <= wd;
    end
    if (rd_en) begin
      qa_r <= hit_a ? wd : mem_a[ra_a];
      qb_r <= hit_b ? wd : mem_b[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      ia_r  <= '0;
      ib_r  <= '0;
    end else begin
      if (we) vld_r[wa] <= 1'b1;
      if (rd_en) begin
        va_r <= vld_r[ra_a] || hit_a;
        vb_r <= vld_r[ra_b] || hit_b;
        ia_r <= ra_a;
        ib_r <= ra_b;
      end
    end
  end

  // x0 reads zero, unwritten entries read their reset value
  always_comb begin
    if (ia_r == '0)      rdata_a = '0;
    else if (va_r)       rdata_a = qa_r;
    else if (ia_r == SP_INDEX) rdata_a = SP_RESET;
    else                 rdata_a = '0;
    if (ib_r == '0)      rdata_b = '0;
    else if (vb_r)       rdata_b = qb_r;
    else if (ib_r == SP_INDEX) rdata_b = SP_RESET;
    else                 rdata_b = '0;
  end

endmodule

// ----- rtl/rv32i_subset_execute.sv -----
// top level of the rv32i subset execute block
// uses rv32x_pkg and rv32x_regfile
//
//  channel  | handshake      | payload
//  in_      | valid / stall  | instr
//  out_     | valid / stall  | next_pc rd_index rd_value rd_write mem_write status
//  cfg_     | valid / ready  | data_base write data
//
// two stages: decode reads the register file (registered), execute computes,
// reads or writes data memory and writes back; an item follows every cycle
// unless stalled. a result is valid once its request reaches stage 2; a load's
// data comes out of the memory with it. the previous instruction is forwarded
// from writeback, the one before it through the register file write-through.
// after reset a clearing pass zeroes the data memory and holds in_stall high;
// afterwards a stalled output holds the whole pipeline.
module rv32i_subset_execute
  import rv32x_pkg::*;
#(
  parameter int DATA_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic [4:0]  out_rd_index,
  output logic [31:0] out_rd_value,
  output logic        out_rd_write,
  output logic        out_mem_write,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam logic [31:0] MEM_BYTES = 32'(DATA_WORDS * 4);

  logic [31:0] base_r;
  logic [31:0] pc_r;
  logic        clr_r;
  logic [AW:0] clr_cnt_r;

  // stage 1 (execute) and stage 2 (writeback) valid
  logic        s1_v_r;
  logic [31:0] s1_ins_r;
  logic        s2_v_r;
  result_t     s2_res_r;
  logic        s2_load_r;

  logic        adv;
  logic [31:0] rf_a, rf_b, a, b;
  logic        wb_we;
  logic [4:0]  wb_wa;
  logic [31:0] wb_wd;
  logic [31:0] ld_data;

  assign adv       = !(s2_v_r && out_stall);
  assign in_stall  = !adv || clr_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= BASE_RESET;
    else if (cfg_valid) base_r <= cfg_data;
  end

  rv32x_regfile u_rf (
    .clk, .rst_n,
    .rd_en   (adv),
    .ra_a    (in_instr[19:15]),
    .ra_b    (in_instr[24:20]),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (wb_we),
    .wa      (wb_wa),
    .wd      (wb_wd)
  );

  // execute stage decode
  logic [6:0]  op;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immu, immj;
  logic [31:0] res, npc, addr, off;
  logic        wr, mw, ld, inr;
  logic [1:0]  st;
  logic        take;

  always_comb begin
    op  = s1_ins_r[6:0];
    rd  = s1_ins_r[11:7];
    f3  = s1_ins_r[14:12];
    rs1 = s1_ins_r[19:15];
    rs2 = s1_ins_r[24:20];
    f7  = s1_ins_r[31:25];
    immi = {{20{s1_ins_r[31]}}, s1_ins_r[31:20]};
    imms = {{20{s1_ins_r[31]}}, s1_ins_r[31:25], s1_ins_r[11:7]};
    immb = {{20{s1_ins_r[31]}}, s1_ins_r[7], s1_ins_r[30:25], s1_ins_r[11:8], 1'b0};
    immu = {s1_ins_r[31:12], 12'd0};
    immj = {{12{s1_ins_r[31]}}, s1_ins_r[19:12], s1_ins_r[20], s1_ins_r[30:21], 1'b0};
  end

  // forward from the previous instruction's writeback (same cycle)
  assign a = (wb_we && wb_wa == rs1 && rs1 != '0) ? wb_wd : rf_a;
  assign b = (wb_we && wb_wa == rs2 && rs2 != '0) ? wb_wd : rf_b;

  always_comb begin
    res  = '0;
    npc  = pc_r + 32'd4;
    wr   = 1'b0;
    mw   = 1'b0;
    ld   = 1'b0;
    st   = ST_OK;
    take = 1'b0;
    addr = a + ((op == OP_STORE) ? imms : immi);
    off  = addr - base_r;
    inr  = off < MEM_BYTES;
    if (op == OP_REG && f7 == 7'd0) begin
      wr = 1'b1;
      case (f3)
        3'd0: res = a + b;
        3'd1: res = a << b[4:0];
        3'd2: res = {31'd0, $signed(a) < $signed(b)};
        3'd3: res = {31'd0, a < b};
        3'd4: res = a ^ b;
        3'd5: res = a >> b[4:0];
        3'd6: res = a | b;
        default: res = a & b;
      endcase
    end else if (op == OP_REG && f7 == 7'h20 && f3 == 3'd0) begin
      wr = 1'b1; res = a - b;
    end else if (op == OP_IMM && f3 == 3'd0) begin
      wr = 1'b1; res = a + immi;
    end else if (op == OP_IMM && f3 == 3'd3) begin
      wr = 1'b1; res = {31'd0, a < immi};
    end else if (op == OP_LOAD && f3 == 3'd2) begin
      if (inr) begin wr = 1'b1; ld = 1'b1; end
      else st = ST_RANGE;
    end else if (op == OP_STORE && f3 == 3'd2) begin
      if (inr) mw = 1'b1;
      else st = ST_RANGE;
    end else if (op == OP_JALR && f3 == 3'd0) begin
      wr = 1'b1; res = pc_r + 32'd4; npc = (a + immi) & ~32'd1;
    end else if (op == OP_BRANCH && f3 != 3'd2 && f3 != 3'd3) begin
      case (f3)
        3'd0: take = a == b;
        3'd1: take = a != b;
        3'd4: take = $signed(a) < $signed(b);
        3'd5: take = $signed(a) >= $signed(b);
        3'd6: take = a < b;
        default: take = a >= b;
      endcase
      if (take) npc = pc_r + immb;
    end else if (op == OP_LUI) begin
      wr = 1'b1; res = immu;
    end else if (op == OP_AUIPC) begin
      wr = 1'b1; res = pc_r + immu;
    end else if (op == OP_JAL) begin
      wr = 1'b1; res = pc_r + 32'd4; npc = pc_r + immj;
    end else begin
      st = ST_UNSUP;
    end
    if (rd == '0) begin wr = 1'b0; ld = 1'b0; end
  end

  // data memory: read and written in execute, zeroed by the clearing pass
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] dq_r;
  logic [AW-1:0] widx;
  logic        ex_fire;

  assign widx    = AW'(off[31:2]);
  assign ex_fire = s1_v_r && adv;

  always_ff @(posedge clk) begin
    if (clr_r) dmem[clr_cnt_r[AW-1:0]] <= '0;
    else if (ex_fire && mw) dmem[widx] <= b;
    if (ex_fire) dq_r <= dmem[widx];
  end

  assign ld_data = dq_r;

  // writeback of the instruction now in stage 2 (load data arrives here)
  assign wb_we = s2_v_r && s2_res_r.rd_write && adv;
  assign wb_wa = s2_res_r.rd_index;
  assign wb_wd = s2_load_r ? ld_data : s2_res_r.rd_value;

  // a load in stage 2 feeding stage 1 is also covered: wb_wd is the load data

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      pc_r      <= '0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      if (adv) begin
        s1_v_r <= in_valid && !clr_r;
        s2_v_r <= s1_v_r;
        if (s1_v_r) pc_r <= npc;
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(DATA_WORDS - 1)) clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ins_r <= in_instr;
      if (s1_v_r) begin
        s2_res_r.next_pc   <= npc;
        s2_res_r.rd_index  <= wr ? rd : '0;
        s2_res_r.rd_value  <= wr ? res : '0;
        s2_res_r.rd_write  <= wr;
        s2_res_r.mem_write <= mw;
        s2_res_r.status    <= st;
        s2_load_r          <= ld;
      end
    end
  end

  assign out_valid     = s2_v_r;
  assign out_next_pc   = s2_res_r.next_pc;
  assign out_rd_index  = s2_res_r.rd_index;
  assign out_rd_value  = wb_wd;
  assign out_rd_write  = s2_res_r.rd_write;
  assign out_mem_write = s2_res_r.mem_write;
  assign out_status    = s2_res_r.status;

endmodule

// ----- rtl/rv32x_checker.sv -----
// port-level checker for rv32i_subset_execute, bound to the top level
// uses assert_macros.svh and rv32x_pkg
`include "assert_macros.svh"
module rv32x_checker
  import rv32x_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_rd_index,
  input logic [31:0] out_rd_value,
  input logic        out_rd_write,
  input logic        out_mem_write,
  input logic [1:0]  out_status
);
  `ASSERT_CLK(a_code, clk, rst_n, out_valid,
    out_status == ST_OK || out_status == ST_UNSUP || out_status == ST_RANGE,
    "undefined status code")
  `ASSERT_NEXT(a_stable, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_rd_value), "stalled result changed")
  `ASSERT_CLK(a_noidx, clk, rst_n, out_valid && !out_rd_write,
    out_rd_index == 5'd0 && out_rd_value == 32'd0, "index without write")
  `ASSERT_CLK(a_onlyone, clk, rst_n, out_valid,
    !(out_rd_write && out_mem_write), "store wrote a register")
  `ASSERT_CLK(a_stat, clk, rst_n, out_valid && out_status != ST_OK,
    !out_rd_write && !out_mem_write, "ignored request changed state")
endmodule

bind rv32i_subset_execute rv32x_checker u_chk (.*);

// ----- dv/rv32i_subset_execute_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for rv32i_subset_execute: directed and random instruction streams
// depends on rv32x_pkg and the rv32i_subset_execute rtl
module rv32i_subset_execute_test;
  import rv32x_pkg::*;

  localparam int MEM_WORDS = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_LW = 3'd2, F3_SW = 3'd2, F3_JALR = 3'd0;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5, F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [6:0] F7_BASE = 7'h00, F7_ALT = 7'h20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_next_pc;
  logic [4:0]  out_rd_index;
  logic [31:0] out_rd_value;
  logic        out_rd_write;
  logic        out_mem_write;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  rv32i_subset_execute #(.DATA_WORDS(MEM_WORDS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_instr(in_instr),
    .out_valid(out_valid), .out_stall(out_stall), .out_next_pc(out_next_pc),
    .out_rd_index(out_rd_index), .out_rd_value(out_rd_value),
    .out_rd_write(out_rd_write), .out_mem_write(out_mem_write), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // architectural shadow state
  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] pc_q;
  logic [31:0] base_q;

  result_t     pending_q [$];
  int          errors = 0;
  int          n_instr = 0;
  int          n_retired = 0;
  int          n_mem = 0;
  int          n_range = 0;
  int          burst_left = 0;
  int          cycles = 0;

  function automatic result_t exec_instr(logic [31:0] ins);
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, npc, immi, imms, immb, immu, immj, res, off;
    logic        wr, mw, take;
    logic [1:0]  st;
    result_t     r;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
    rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
    a = gpr[rs1]; b = gpr[rs2];
    npc = pc_q + 32'd4;
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immu = {ins[31:12], 12'd0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    res = '0; wr = 1'b0; mw = 1'b0; st = ST_OK; off = '0;
    if (op == OP_REG && f7 == F7_BASE) begin
      wr = 1'b1;
      case (f3)
        F3_ADD:  res = a + b;
        F3_SLL:  res = a << b[4:0];
        F3_SLT:  res = {31'd0, $signed(a) < $signed(b)};
        F3_SLTU: res = {31'd0, a < b};
        F3_XOR:  res = a ^ b;
        F3_SRL:  res = a >> b[4:0];
        F3_OR:   res = a | b;
        default: res = a & b;
      endcase
    end else if (op == OP_REG && f7 == F7_ALT && f3 == F3_ADD) begin
      wr = 1'b1; res = a - b;
    end else if (op == OP_IMM && f3 == F3_ADD) begin
      wr = 1'b1; res = a + immi;
    end else if (op == OP_IMM && f3 == F3_SLTU) begin
      wr = 1'b1; res = {31'd0, a < immi};
    end else if (op == OP_LOAD && f3 == F3_LW) begin
      off = a + immi - base_q;
      if (off < 4 * MEM_WORDS) begin
        wr = 1'b1; res = dmem[off[6:2]];
      end else st = ST_RANGE;
    end else if (op == OP_STORE && f3 == F3_SW) begin
      off = a + imms - base_q;
      if (off < 4 * MEM_WORDS) begin
        dmem[off[6:2]] = b; mw = 1'b1;
      end else st = ST_RANGE;
    end else if (op == OP_JALR && f3 == F3_JALR) begin
      wr = 1'b1; res = pc_q + 32'd4; npc = (a + immi) & ~32'd1;
    end else if (op == OP_BRANCH && f3 != 3'd2 && f3 != 3'd3) begin
      case (f3)
        F3_BEQ:  take = a == b;
        F3_BNE:  take = a != b;
        F3_BLT:  take = $signed(a) < $signed(b);
        F3_BGE:  take = $signed(a) >= $signed(b);
        F3_BLTU: take = a < b;
        default: take = a >= b;
      endcase
      if (take) npc = pc_q + immb;
    end else if (op == OP_LUI) begin
      wr = 1'b1; res = immu;
    end else if (op == OP_AUIPC) begin
      wr = 1'b1; res = pc_q + immu;
    end else if (op == OP_JAL) begin
      wr = 1'b1; res = pc_q + 32'd4; npc = pc_q + immj;
    end else st = ST_UNSUP;
    if (rd == 5'd0) wr = 1'b0;
    if (wr) gpr[rd] = res;
    pc_q = npc;
    r.next_pc = npc;
    r.rd_index = wr ? rd : 5'd0;
    r.rd_value = wr ? res : 32'd0;
    r.rd_write = wr;
    r.mem_write = mw;
    r.status = st;
    if (mw) n_mem++;
    if (st == ST_RANGE) n_range++;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3_SW, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // send one request, predicting its result on acceptance
  task automatic send_instr(logic [31:0] ins);
    int gap;
    bit acc;
    result_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_instr <= ins;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    pred = exec_instr(ins);
    pending_q.insert(pending_q.size(), pred);
    n_instr++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    bit acc;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    base_q = v;
  endtask

  // load a 32-bit constant with lui + addi
  task automatic set_reg(logic [4:0] r, logic [31:0] v);
    logic [31:0] hi;
    hi = v + 32'h800;
    send_instr({hi[31:12], r, OP_LUI});
    send_instr(enc_i(v[11:0], r, F3_ADD, r, OP_IMM));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_retired);
  endtask

  // result checker, sampled mid-cycle so nothing races the edge
  bit          ret_seen;
  result_t     ret_got;
  always @(negedge clk) begin
    ret_seen <= rst_n && out_valid && !out_stall;
    ret_got <= '{out_next_pc, out_rd_index, out_rd_value, out_rd_write, out_mem_write,
                 out_status};
  end

  always @(posedge clk) begin
    result_t w;
    if (ret_seen) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", ret_got.next_pc, '0);
      end else begin
        w = pending_q.pop_front();
        if (ret_got.next_pc !== w.next_pc) report_mismatch("next_pc", ret_got.next_pc, w.next_pc);
        if (ret_got.rd_index !== w.rd_index)
          report_mismatch("rd_index", ret_got.rd_index, w.rd_index);
        if (ret_got.rd_value !== w.rd_value)
          report_mismatch("rd_value", ret_got.rd_value, w.rd_value);
        if (ret_got.rd_write !== w.rd_write)
          report_mismatch("rd_write", ret_got.rd_write, w.rd_write);
        if (ret_got.mem_write !== w.mem_write)
          report_mismatch("mem_write", ret_got.mem_write, w.mem_write);
        if (ret_got.status !== w.status) report_mismatch("status", ret_got.status, w.status);
      end
      n_retired++;
    end
  end

  // receiver stall pattern: runs of free flow, light and heavy back-pressure
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_alu_extremes();
    set_reg(5'd1, 32'hFFFF_FFFF);
    set_reg(5'd3, 32'h8000_0000);
    set_reg(5'd4, 32'd31);
    for (int f = 0; f < 8; f++) send_instr(enc_r(F7_BASE, 5'd4, 5'd3, f[2:0], 5'd5, OP_REG));
    send_instr(enc_r(F7_ALT, 5'd1, 5'd3, F3_ADD, 5'd6, OP_REG));      // sub
    send_instr(enc_r(F7_ALT, 5'd4, 5'd3, F3_SRL, 5'd6, OP_REG));      // sra: unsupported
    send_instr(enc_r(F7_BASE, 5'd1, 5'd3, F3_SLT, 5'd7, OP_REG));
    send_instr(enc_i(12'hFFF, 5'd3, F3_SLTU, 5'd8, OP_IMM));
    send_instr(enc_i(12'h800, 5'd1, F3_ADD, 5'd0, OP_IMM));           // x0 destination
    send_instr(32'hFFFF_FFFF);
    send_instr(32'h0000_0000);
  endtask

  task automatic test_flow_and_memory();
    send_instr({20'hFFFFF, 5'd9, OP_AUIPC});
    send_instr(enc_j(21'h1FFFFC, 5'd1));                              // backward jal
    send_instr(enc_i(12'h7FF, 5'd3, F3_JALR, 5'd1, OP_IMM ^ OP_IMM ^ OP_JALR));
    send_instr(enc_i(12'h001, 5'd0, F3_SLL, 5'd1, OP_JALR));          // bad jalr funct3
    for (int f = 0; f < 8; f++) send_instr(enc_b(13'h1FF8, 5'd1, 5'd3, f[2:0]));
    set_reg(5'd10, base_q);
    send_instr(enc_s(12'd124, 5'd3, 5'd10));
    send_instr(enc_i(12'd124, 5'd10, F3_LW, 5'd11, OP_LOAD));
    send_instr(enc_i(12'd128, 5'd10, F3_LW, 5'd11, OP_LOAD));         // just past the window
    send_instr(enc_s(12'hFFC, 5'd3, 5'd10));                          // just before it
    send_instr(enc_i(12'd0, 5'd10, F3_ADD, 5'd11, OP_LOAD));          // lb: unsupported
  endtask

  function automatic logic [4:0] rnd_reg();
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic random_instr();
    int k;
    logic [4:0] r;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      send_instr(enc_r(($urandom_range(0, 4) == 0) ? F7_ALT : F7_BASE, rnd_reg(), rnd_reg(),
                       3'($urandom_range(0, 7)), rnd_reg(), OP_REG));
    end else if (k < 37) begin
      send_instr(enc_i(12'($urandom), rnd_reg(), $urandom_range(0, 1) ? F3_ADD : F3_SLTU,
                       rnd_reg(), OP_IMM));
    end else if (k < 57) begin
      // address setup then a load or store, mostly inside the window
      r = 5'($urandom_range(1, 31));
      set_reg(r, base_q + $urandom_range(0, 160) - 16);
      if ($urandom_range(0, 1))
        send_instr(enc_s(12'($urandom_range(0, 31) * 4 - 16), rnd_reg(), r));
      else
        send_instr(enc_i(12'($urandom_range(0, 31) * 4 - 16), r, F3_LW, rnd_reg(), OP_LOAD));
    end else if (k < 69) begin
      send_instr(enc_b(13'($urandom), rnd_reg(), rnd_reg(), 3'($urandom_range(0, 7))));
    end else if (k < 77) begin
      send_instr({20'($urandom), rnd_reg(), $urandom_range(0, 1) ? OP_LUI : OP_AUIPC});
    end else if (k < 84) begin
      send_instr(enc_j(21'($urandom), rnd_reg()));
    end else if (k < 90) begin
      send_instr(enc_i(12'($urandom), rnd_reg(),
                       ($urandom_range(0, 3) == 0) ? 3'($urandom) : F3_JALR,
                       rnd_reg(), OP_JALR));
    end else begin
      send_instr($urandom);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) random_instr();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
    gpr[SP_INDEX] = SP_RESET;
    pc_q = '0;
    base_q = BASE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alu_extremes();
    test_flow_and_memory();
    write_base(32'd0);
    test_random(150);
    write_base(32'hFFFF_FFC0);      // window wraps through zero
    test_random(150);
    write_base(32'hFFFF_FFFF);
    test_random(120);
    write_base($urandom);
    test_random(150);
    write_base(BASE_RESET);
    test_random(150);
    drain();
    repeat (10) @(posedge clk);
    $display("ran %0d instructions over 5 data windows, %0d results checked", n_instr, n_retired);
    $display("stores landed %0d, out-of-window accesses %0d", n_mem, n_range);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rv32x_pkg.sv
rtl/rv32x_regfile.sv
rtl/rv32i_subset_execute.sv
rtl/rv32x_checker.sv
dv/rv32i_subset_execute_test.sv
